/* src/eth_ip_tcp_header_parser_macros.svh */
// Assertion macros for the Ethernet/IP/TCP header parser.
// Included by RTL files that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ETH_IP_TCP_HEADER_PARSER_MACROS_SVH
`define ETH_IP_TCP_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ETHP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ETHP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ethp_pkg.sv */
// Shared types and constants for the Ethernet/IP/TCP header parser.
// No dependencies.
`default_nettype none

package ethp_pkg;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'h06;

  localparam logic [7:0]  POS_MAX        = 8'hFF;
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [7:0]  IPV6_TCP_START = 8'd54;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_TCP4  = 2'd1,
    KIND_TCP6  = 2'd2,
    KIND_BAD   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    kind_e        kind;
    logic [47:0]  dst_mac;
    logic [47:0]  src_mac;
    logic [63:0]  src_ip_high;
    logic [63:0]  src_ip_low;
    logic [63:0]  dst_ip_high;
    logic [63:0]  dst_ip_low;
    logic [15:0]  src_port;
    logic [15:0]  dst_port;
    logic [7:0]   payload_offset;
    logic [15:0]  payload_length;
  } out_t;

  // Per-frame parse state.
  typedef struct packed {
    logic [7:0]  pos;
    logic [15:0] ether_kind;
    logic [3:0]  ip_header_words;
    logic [7:0]  ip_protocol;
    logic [15:0] ip_length_field;
    logic [7:0]  tcp_start;
    logic [3:0]  tcp_header_words;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [63:0] src_ip_hi;
    logic [63:0] src_ip_lo;
    logic [63:0] dst_ip_hi;
    logic [63:0] dst_ip_lo;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } frame_state_t;

  localparam frame_state_t FRAME_STATE_RESET = '0;

endpackage

`default_nettype wire

/* src/ethp_capture.sv */
// Byte-position tracker and header field capture registers.
// Depends on ethp_pkg.
`default_nettype none
`include "eth_ip_tcp_header_parser_macros.svh"

module ethp_capture
  import ethp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         take_i,
  input  wire in_t          byte_i,
  output frame_state_t      view_o,
  output logic [7:0]        pos_o
);

  frame_state_t st_q, st_d;
  logic [7:0] p;
  logic [7:0] b;
  logic [7:0] ts;

  assign p  = st_q.pos;
  assign b  = byte_i.data_byte;
  assign ts = st_q.tcp_start;

  always_comb begin
    st_d = st_q;
    if (take_i && (p != POS_MAX)) begin
      if (p < 8'd6) begin
        st_d.dst_mac = {st_q.dst_mac[39:0], b};
      end else if (p < 8'd12) begin
        st_d.src_mac = {st_q.src_mac[39:0], b};
      end else if (p < ETH_HDR_LEN) begin
        st_d.ether_kind = {st_q.ether_kind[7:0], b};
      end

      // TCP fields use the start offset as it stood before this byte
      if (ts != 8'd0) begin
        if ((p == ts) || (p == 8'(ts + 8'd1))) begin
          st_d.src_port = {st_q.src_port[7:0], b};
        end else if ((p == 8'(ts + 8'd2)) || (p == 8'(ts + 8'd3))) begin
          st_d.dst_port = {st_q.dst_port[7:0], b};
        end else if (p == 8'(ts + 8'd12)) begin
          st_d.tcp_header_words = b[7:4];
        end
      end

      if ((p == 8'd13) && (st_d.ether_kind == ETH_IPV6)) begin
        st_d.tcp_start = IPV6_TCP_START;
      end

      if ((st_d.ether_kind == ETH_IPV4) && (p >= ETH_HDR_LEN)) begin
        if (p == 8'd14) begin
          st_d.ip_header_words = b[3:0];
          st_d.tcp_start       = 8'(ETH_HDR_LEN + {2'b00, b[3:0], 2'b00});
        end else if ((p == 8'd16) || (p == 8'd17)) begin
          st_d.ip_length_field = {st_q.ip_length_field[7:0], b};
        end else if (p == 8'd23) begin
          st_d.ip_protocol = b;
        end else if ((p >= 8'd26) && (p < 8'd30)) begin
          st_d.src_ip_lo = {st_q.src_ip_lo[55:0], b};
        end else if ((p >= 8'd30) && (p < 8'd34)) begin
          st_d.dst_ip_lo = {st_q.dst_ip_lo[55:0], b};
        end
      end else if ((st_d.ether_kind == ETH_IPV6) && (p >= ETH_HDR_LEN)) begin
        if ((p == 8'd18) || (p == 8'd19)) begin
          st_d.ip_length_field = {st_q.ip_length_field[7:0], b};
        end else if (p == 8'd20) begin
          st_d.ip_protocol = b;
        end else if ((p >= 8'd22) && (p < 8'd30)) begin
          st_d.src_ip_hi = {st_q.src_ip_hi[55:0], b};
        end else if ((p >= 8'd30) && (p < 8'd38)) begin
          st_d.src_ip_lo = {st_q.src_ip_lo[55:0], b};
        end else if ((p >= 8'd38) && (p < 8'd46)) begin
          st_d.dst_ip_hi = {st_q.dst_ip_hi[55:0], b};
        end else if ((p >= 8'd46) && (p < IPV6_TCP_START)) begin
          st_d.dst_ip_lo = {st_q.dst_ip_lo[55:0], b};
        end
      end

      st_d.pos = 8'(p + 8'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FRAME_STATE_RESET;
    end else if (take_i) begin
      st_q <= byte_i.frame_end ? FRAME_STATE_RESET : st_d;
    end
  end

  assign view_o = st_d;
  assign pos_o  = p;

  `ETHP_ASSERT_NXT(a_clear_after_last, take_i && byte_i.frame_end, st_q.pos == 8'd0,
    "parse state not cleared after last byte")
  `ETHP_ASSERT_NXT(a_pos_holds_at_max, take_i && (p == POS_MAX) && !byte_i.frame_end,
    st_q.pos == POS_MAX, "byte position left saturation")
  `ETHP_ASSERT_IMP(a_v6_start, (p > 8'd13) && (st_q.ether_kind == ETH_IPV6),
    ts == IPV6_TCP_START, "IPv6 TCP start offset wrong")

endmodule

`default_nettype wire

/* src/ethp_classify.sv */
// Frame classification and result formatting from the updated parse state.
// Depends on ethp_pkg.
`default_nettype none

module ethp_classify
  import ethp_pkg::*;
(
  input  wire frame_state_t view_i,
  input  wire logic [7:0] pos_i,
  output out_t          res_o
);

  kind_e       kind;
  logic [8:0]  ports_end;
  logic [6:0]  sub;
  logic [15:0] sub16;

  assign ports_end = 9'({1'b0, view_i.tcp_start} + 9'd3);

  always_comb begin
    kind = KIND_OTHER;
    if (pos_i < 8'd13) begin
      kind = KIND_BAD;
    end else if (view_i.ether_kind == ETH_IPV4) begin
      if (pos_i < 8'd23) begin
        kind = KIND_BAD;
      end else if (view_i.ip_protocol != PROTO_TCP) begin
        kind = KIND_OTHER;
      end else if (view_i.ip_header_words < MIN_HDR_WORDS) begin
        kind = KIND_BAD;
      end else if ({1'b0, pos_i} < ports_end) begin
        kind = KIND_BAD;
      end else if (view_i.tcp_header_words < MIN_HDR_WORDS) begin
        kind = KIND_BAD;
      end else begin
        kind = KIND_TCP4;
      end
    end else if (view_i.ether_kind == ETH_IPV6) begin
      if (pos_i < 8'd20) begin
        kind = KIND_BAD;
      end else if (view_i.ip_protocol != PROTO_TCP) begin
        kind = KIND_OTHER;
      end else if ({1'b0, pos_i} < ports_end) begin
        kind = KIND_BAD;
      end else if (view_i.tcp_header_words < MIN_HDR_WORDS) begin
        kind = KIND_BAD;
      end else begin
        kind = KIND_TCP6;
      end
    end
  end

  // header bytes to strip from the IP length; IPv6 length excludes the IP header
  always_comb begin
    sub = {1'b0, view_i.tcp_header_words, 2'b00};
    if (kind == KIND_TCP4) begin
      sub = 7'(sub + {1'b0, view_i.ip_header_words, 2'b00});
    end
  end

  assign sub16 = {9'd0, sub};

  always_comb begin
    res_o      = '0;
    res_o.kind = kind;
    if ((kind == KIND_TCP4) || (kind == KIND_TCP6)) begin
      res_o.dst_mac        = view_i.dst_mac;
      res_o.src_mac        = view_i.src_mac;
      res_o.src_ip_high    = view_i.src_ip_hi;
      res_o.src_ip_low     = view_i.src_ip_lo;
      res_o.dst_ip_high    = view_i.dst_ip_hi;
      res_o.dst_ip_low     = view_i.dst_ip_lo;
      res_o.src_port       = view_i.src_port;
      res_o.dst_port       = view_i.dst_port;
      res_o.payload_offset = 8'(view_i.tcp_start + {2'b00, view_i.tcp_header_words, 2'b00});
      res_o.payload_length = (view_i.ip_length_field > sub16) ?
                             16'(view_i.ip_length_field - sub16) : 16'd0;
    end
  end

endmodule

`default_nettype wire

/* src/eth_ip_tcp_header_parser.sv */
// Ethernet/IPv4/IPv6 TCP header parser, one frame byte per transaction.
// Throughput: one byte per cycle while no last byte is stalled, through input register, capture and result register.
// Result path: the last byte passes the input register, then its result is loaded into the result register.
// Input stalls only while a last byte waits on a result register that has not been taken.
// Reset: asynchronous, clears the parse state and both valid flags; no clearing pass.
`default_nettype none
`include "eth_ip_tcp_header_parser_macros.svh"

module eth_ip_tcp_header_parser
  import ethp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  logic         in_valid_q;
  in_t          in_q;
  logic         out_valid_q;
  out_t         out_q;
  logic         out_free;
  logic         consume;
  logic         load_res;
  frame_state_t view;
  logic [7:0]   pos;
  out_t         res;

  assign out_free   = !out_valid_q || out_ready_i;
  // bytes that give no result pass even while a result is waiting
  assign consume    = in_valid_q && (!in_q.frame_end || out_free);
  assign in_ready_o = !in_valid_q || consume;
  assign load_res   = consume && in_q.frame_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_i;
    end
  end

  ethp_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (consume),
    .byte_i (in_q),
    .view_o (view),
    .pos_o  (pos)
  );

  ethp_classify u_classify (
    .view_i (view),
    .pos_i  (pos),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ETHP_ASSERT_IMP(a_stall_cause, in_valid_q && !consume,
    in_q.frame_end && out_valid_q && !out_ready_i, "input stalled without a pending result")
  `ETHP_ASSERT_NXT(a_result_loaded, load_res, out_valid_q, "last byte gave no result")
  `ETHP_ASSERT_IMP(a_zero_fields, out_valid_q && ((out_q.kind == KIND_OTHER) ||
    (out_q.kind == KIND_BAD)), (out_q.dst_mac == 48'd0) && (out_q.payload_length == 16'd0),
    "non-TCP result carries field data")
  `ETHP_ASSERT_IMP(a_min_offset, out_valid_q && ((out_q.kind == KIND_TCP4) ||
    (out_q.kind == KIND_TCP6)), out_q.payload_offset >= 8'd54,
    "TCP payload offset below minimum headers")

endmodule

`default_nettype wire
